@@ hdl/cvd_pkg.sv @@
// Shared types and constants for the canonical varint decoder.
package cvd_pkg;

	localparam int VALUE_W = 64;
	localparam int GROUP_W = 7;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 4;
	localparam int LEN_W   = 4;
	localparam int SHIFT_W = 6;

	// Index of the tenth and final group a varint may hold.
	localparam logic [IDX_W-1:0] LAST_IDX = 4'd9;
	localparam logic [VALUE_W-1:0] LIMIT_RESET = {VALUE_W{1'b1}};

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNCATED = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_NONCANON  = 3'd3,
		ST_TOOLONG   = 3'd4,
		ST_OVERLIMIT = 3'd5
	} status_t;

	// Contents of the input register handed to the decode stage.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_buffer;
	} byte_stage_t;

endpackage

@@ hdl/cvd_if.sv @@
// Valid/ready channel interfaces for the byte stream and the decoded results.
interface cvd_byte_if import cvd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface cvd_result_if import cvd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] decoded_value;
	status_t            status;
	logic [LEN_W-1:0]   encoded_length;

	modport source (output valid, output decoded_value, output status,
		output encoded_length, input ready);
	modport sink (input valid, input decoded_value, input status,
		input encoded_length, output ready);
endinterface

@@ hdl/cvd_in_stage.sv @@
// Input register: captures one byte transfer and holds it for the decode stage.
module cvd_in_stage import cvd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	cvd_byte_if.sink      stream,
	input  logic          advance,
	output byte_stage_t   stage
);

	logic              valid_s1;
	logic [BYTE_W-1:0] data_byte_s1;
	logic              end_of_buffer_s1;

	// A new byte may enter whenever the register is empty or is moving on.
	assign stream.ready = !valid_s1 || advance;

	// Control bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the stage needs no reset.
	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_byte_s1     <= stream.data_byte;
			end_of_buffer_s1 <= stream.end_of_buffer;
		end
	end

	assign stage.valid         = valid_s1;
	assign stage.data_byte     = data_byte_s1;
	assign stage.end_of_buffer = end_of_buffer_s1;

endmodule

@@ hdl/cvd_decode.sv @@
// Decode stage: varint state, error checks and the result register.
module cvd_decode import cvd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  byte_stage_t        stage,
	input  logic [VALUE_W-1:0] limit,
	output logic               advance,
	cvd_result_if.source       result
);

	logic [VALUE_W-1:0] acc_q;
	logic [IDX_W-1:0]   idx_q;
	logic               failed_q;

	logic               res_valid_q;
	logic [VALUE_W-1:0] res_value_q;
	status_t            res_status_q;
	logic [LEN_W-1:0]   res_len_q;

	logic [VALUE_W-1:0] acc_d;
	logic [IDX_W-1:0]   idx_d;
	logic               failed_d;
	logic               emit;
	status_t            status;
	logic [VALUE_W-1:0] value;
	logic [LEN_W-1:0]   len;
	logic [GROUP_W-1:0] payload;
	logic               cont;
	logic [SHIFT_W-1:0] shift_amt;
	logic [VALUE_W-1:0] shifted;
	logic [VALUE_W-1:0] acc_merge;
	logic               fire;

	// The stage moves on when the result register is free or being emptied.
	assign advance = !res_valid_q || result.ready;
	assign fire    = stage.valid && advance;

	assign payload = stage.data_byte[GROUP_W-1:0];
	assign cont    = stage.data_byte[BYTE_W-1];
	assign len     = LEN_W'(idx_q) + LEN_W'(1);

	// Bit position of the current group is seven times the group index.
	assign shift_amt = SHIFT_W'({idx_q, 3'b000} - {3'b000, idx_q});
	assign shifted   = {{(VALUE_W-GROUP_W){1'b0}}, payload} << shift_amt;
	assign acc_merge = acc_q | shifted;

	// Next state and result for the byte held in the input register.
	always_comb begin
		acc_d    = acc_q;
		idx_d    = idx_q;
		failed_d = failed_q;
		emit     = 1'b0;
		status   = ST_OK;
		value    = '0;
		if (failed_q || idx_q > LAST_IDX) begin
			if (!failed_q) begin
				acc_d = '0;
				idx_d = '0;
			end
		end else begin
			if (idx_q == LAST_IDX && payload > GROUP_W'(1)) begin
				emit   = 1'b1;
				status = ST_OVERFLOW;
			end else if (!cont) begin
				emit = 1'b1;
				if (idx_q != '0 && stage.data_byte == '0) begin
					status = ST_NONCANON;
				end else if (acc_merge > limit) begin
					status = ST_OVERLIMIT;
				end else begin
					value = acc_merge;
				end
			end else if (idx_q == LAST_IDX) begin
				emit   = 1'b1;
				status = ST_TOOLONG;
			end else if (stage.end_of_buffer) begin
				emit   = 1'b1;
				status = ST_TRUNCATED;
			end else begin
				idx_d = IDX_W'(len);
				acc_d = acc_merge;
			end
			// Any result closes the varint; an error also blocks the rest.
			if (emit) begin
				acc_d = '0;
				idx_d = '0;
				if (status != ST_OK) begin
					failed_d = 1'b1;
				end
			end
		end
		// The last byte of a buffer always starts the next one afresh.
		if (stage.end_of_buffer) begin
			acc_d    = '0;
			idx_d    = '0;
			failed_d = 1'b0;
		end
	end

	// Varint state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			idx_q       <= '0;
			failed_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				acc_q    <= acc_d;
				idx_q    <= idx_d;
				failed_q <= failed_d;
			end
			if (fire && emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_value_q  <= value;
			res_status_q <= status;
			res_len_q    <= len;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.decoded_value  = res_value_q;
	assign result.status         = res_status_q;
	assign result.encoded_length = res_len_q;

	// A varint never gathers more than ten groups.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("group index beyond the tenth group");

	// While a buffer has failed no partial varint is kept.
	a_failed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |-> (idx_q == '0 && acc_q == '0))
		else $error("partial varint kept after a failure");

	// Errored results carry a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_status_q != ST_OK) |-> res_value_q == '0)
		else $error("error result with a non-zero value");

	// A canonical multi-byte value needs more than one group of bits.
	a_ok_canon: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_status_q == ST_OK && res_len_q > LEN_W'(1))
		|-> res_value_q[VALUE_W-1:GROUP_W] != '0)
		else $error("non-canonical value reported as good");

	// Reported length lies between one and ten bytes.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_len_q != '0 && res_len_q <= LEN_W'(LAST_IDX) + LEN_W'(1)))
		else $error("encoded length out of range");

endmodule

@@ hdl/canonical_varint_decoder.sv @@
// Each byte is held in the input register; its result is loaded into the result register and offered from there.
// Throughput: one byte per cycle while results are taken; set by the single decode stage and its result register.
// A waiting result stalls the decode stage; the full input register then holds off the stream.
// Reset (arst_n, asynchronous, active low) empties both registers, clears the varint
// state and the failure flag, and sets the value limit to all ones.
module canonical_varint_decoder import cvd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	cvd_byte_if.sink           stream,
	cvd_result_if.source       result,
	input  logic               limit_we,
	input  logic [VALUE_W-1:0] limit_wdata
);

	logic [VALUE_W-1:0] limit_q;
	logic               advance;
	byte_stage_t        stage;

	// Value limit register, written through the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	cvd_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream),
		.advance (advance),
		.stage   (stage)
	);

	cvd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.limit   (limit_q),
		.advance (advance),
		.result  (result)
	);

endmodule

@@ test/cvd_checker.sv @@
// Result checker for the canonical varint decoder: predicts each result and compares it.
`timescale 1ns / 1ps

module cvd_checker import cvd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	cvd_byte_if                byte_ch,
	cvd_result_if              res_ch,
	input  logic               limit_we,
	input  logic [VALUE_W-1:0] limit_wdata,
	output int                 failures,
	output int                 outstanding
);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
		logic [LEN_W-1:0]   len;
	} varint_result_t;

	// Shadow copy of the decoder state and its value limit.
	logic [VALUE_W-1:0] acc;
	logic [IDX_W-1:0]   grp_idx;
	logic               failed;
	logic [VALUE_W-1:0] value_limit;

	varint_result_t pending_results[$];

	// Decodes one byte against the shadow state; returns 1 when the byte yields a result.
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic eob,
			output varint_result_t r);
		logic [GROUP_W-1:0] payload;
		int unsigned        shift;
		bit                 hit;
		payload = b[GROUP_W-1:0];
		hit = 1'b0;
		r = '0;
		// While a failure is pending in this buffer every byte is dropped.
		if (failed || grp_idx > LAST_IDX) begin
			if (!failed) begin
				acc = '0;
				grp_idx = '0;
			end
			if (eob) begin
				failed = 1'b0;
				acc = '0;
				grp_idx = '0;
			end
			return 1'b0;
		end
		r.len = LEN_W'(grp_idx) + LEN_W'(1);
		shift = grp_idx * GROUP_W;
		if (grp_idx == LAST_IDX && payload > 1) begin
			hit = 1'b1;
			r.status = ST_OVERFLOW;
		end else begin
			acc = acc | (VALUE_W'(payload) << shift);
			if (!b[BYTE_W-1]) begin
				hit = 1'b1;
				if (grp_idx != 0 && b == '0) begin
					r.status = ST_NONCANON;
				end else if (acc > value_limit) begin
					r.status = ST_OVERLIMIT;
				end else begin
					r.status = ST_OK;
					r.value = acc;
				end
			end else if (grp_idx == LAST_IDX) begin
				hit = 1'b1;
				r.status = ST_TOOLONG;
			end else if (eob) begin
				hit = 1'b1;
				r.status = ST_TRUNCATED;
			end else begin
				grp_idx = r.len;
			end
		end
		if (hit) begin
			if (r.status != ST_OK) begin
				failed = 1'b1;
			end
			acc = '0;
			grp_idx = '0;
		end
		if (eob) begin
			failed = 1'b0;
			acc = '0;
			grp_idx = '0;
		end
		return hit;
	endfunction

	// Watch both channels at every edge; results are checked before new bytes are predicted.
	always @(posedge clk or negedge arst_n) begin
		varint_result_t want;
		varint_result_t got;
		if (!arst_n) begin
			acc = '0;
			grp_idx = '0;
			failed = 1'b0;
			value_limit = LIMIT_RESET;
			pending_results.delete();
			failures = 0;
			outstanding <= 0;
		end else begin
			// Compare an accepted result with the oldest prediction.
			if (res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, %s %h %0d %0d",
						$time, "got value, status and length",
						res_ch.decoded_value, res_ch.status, res_ch.encoded_length);
					failures++;
				end else begin
					want = pending_results.pop_front();
					if (res_ch.decoded_value !== want.value) begin
						$display("%0t: decoded_value mismatch: expected %h, got %h",
							$time, want.value, res_ch.decoded_value);
						failures++;
					end
					if (res_ch.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, want.status, res_ch.status);
						failures++;
					end
					if (res_ch.encoded_length !== want.len) begin
						$display("%0t: encoded_length mismatch: expected %0d, got %0d",
							$time, want.len, res_ch.encoded_length);
						failures++;
					end
				end
			end
			// Predict the outcome of an accepted byte transfer.
			if (byte_ch.valid && byte_ch.ready) begin
				if (decode_byte(byte_ch.data_byte, byte_ch.end_of_buffer, got)) begin
					pending_results = {pending_results, got};
				end
			end
			if (limit_we) begin
				value_limit = limit_wdata;
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

@@ test/canonical_varint_decoder_tb.sv @@
// Top of the canonical varint decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module canonical_varint_decoder_tb;
	import cvd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_OFF    = 4;
	localparam int SEGMENTS    = 12;
	localparam int SEG_BYTES   = 114;

	typedef enum {
		SHAPE_CANON,
		SHAPE_NONCANON,
		SHAPE_OVERFLOW,
		SHAPE_TOOLONG,
		SHAPE_NOISE,
		SHAPE_TRUNC
	} shape_t;

	logic               clk;
	logic               arst_n;
	logic               limit_we;
	logic [VALUE_W-1:0] limit_wdata;
	int                 failures;
	int                 outstanding;
	int                 src_idle_pct;
	int                 sink_idle_pct;
	int                 bytes_sent;
	int                 stall_cycles;
	logic [VALUE_W-1:0] limit_plan [SEGMENTS];

	cvd_byte_if   byte_ch ();
	cvd_result_if res_ch ();

	canonical_varint_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.stream      (byte_ch),
		.result      (res_ch),
		.limit_we    (limit_we),
		.limit_wdata (limit_wdata)
	);

	cvd_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_ch     (byte_ch),
		.res_ch      (res_ch),
		.limit_we    (limit_we),
		.limit_wdata (limit_wdata),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// Free-running clock, 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver drops ready at random according to its current idle rate.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// The run is ended if no transfer happens on either channel for too long.
	initial begin : watchdog
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Offers one byte, with a random gap first, and returns at the edge of its transfer.
	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eob);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(0, 99) < src_idle_pct);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.end_of_buffer <= eob;
		@(posedge clk);
		while (!byte_ch.ready) begin
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	// Stops the stream and waits until every predicted result has been received.
	task automatic settle();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	// Writes the value limit once the decoder has gone quiet.
	task automatic write_limit(input logic [VALUE_W-1:0] val);
		settle();
		limit_we <= 1'b1;
		limit_wdata <= val;
		@(posedge clk);
		limit_we <= 1'b0;
	endtask

	// Sends one varint of a random shape; closes marks the last varint of a buffer.
	task automatic send_varint(input bit closes);
		shape_t             shape;
		int                 r;
		int                 len;
		bit                 fill;
		bit                 is_last;
		logic [BYTE_W-1:0]  b;
		logic               eob;
		logic [GROUP_W-1:0] mid;
		r = $urandom_range(0, 99);
		if (r < 68) shape = SHAPE_CANON;
		else if (r < 74) shape = SHAPE_NONCANON;
		else if (r < 79) shape = SHAPE_OVERFLOW;
		else if (r < 84) shape = SHAPE_TOOLONG;
		else if (r < 90) shape = SHAPE_NOISE;
		else shape = closes ? SHAPE_TRUNC : SHAPE_CANON;
		// Mostly short varints, a few up to the full ten bytes.
		r = $urandom_range(0, 99);
		if (r < 50) len = $urandom_range(1, 2);
		else if (r < 80) len = $urandom_range(3, 5);
		else len = $urandom_range(6, 10);
		if (shape == SHAPE_NONCANON && len < 2) len = 2;
		if (shape == SHAPE_OVERFLOW || shape == SHAPE_TOOLONG) len = 10;
		fill = ($urandom_range(0, 9) == 0);
		for (int i = 0; i < len; i++) begin
			is_last = (i == len - 1);
			if (fill) mid = 7'h7F;
			else if ($urandom_range(0, 7) == 0) mid = 7'h00;
			else mid = GROUP_W'($urandom);
			b = {1'b1, mid};
			if (is_last) begin
				case (shape)
					SHAPE_CANON: begin
						if (len == 1) b = {1'b0, fill ? 7'h7F : GROUP_W'($urandom)};
						else if (len == 10) b = 8'h01;
						else b = {1'b0, fill ? 7'h7F : GROUP_W'($urandom_range(1, 127))};
					end
					SHAPE_NONCANON: b = 8'h00;
					SHAPE_OVERFLOW: b = {1'($urandom), GROUP_W'($urandom_range(2, 127))};
					default: b = b;
				endcase
			end
			if (shape == SHAPE_NOISE) b = BYTE_W'($urandom);
			// A stray end mark now and then cuts a varint short.
			eob = (closes && is_last) || ($urandom_range(0, 49) == 0);
			push_byte(b, eob);
		end
	endtask

	// A buffer is a handful of varints; the last byte carries the end mark.
	task automatic send_buffer();
		int count;
		count = $urandom_range(1, 5);
		for (int v = 0; v < count; v++) begin
			send_varint(v == count - 1);
		end
	endtask

	// Main sequence: reset, directed cases, then random phases under several limits.
	initial begin
		int target;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		byte_ch.end_of_buffer <= 1'b0;
		limit_we <= 1'b0;
		limit_wdata <= '0;
		bytes_sent = 0;
		src_idle_pct = 11;
		sink_idle_pct = 68;
		limit_plan[0]  = LIMIT_RESET;
		limit_plan[1]  = '0;
		limit_plan[2]  = 64'd127;
		limit_plan[3]  = 64'd128;
		limit_plan[4]  = 64'd16383;
		limit_plan[5]  = 64'h0000_0000_FFFF_FFFF;
		limit_plan[6]  = 64'h8000_0000_0000_0000;
		limit_plan[7]  = LIMIT_RESET - VALUE_W'(1);
		limit_plan[8]  = {$urandom, $urandom};
		limit_plan[9]  = {$urandom, $urandom} >> $urandom_range(0, 63);
		limit_plan[10] = 64'h7FFF_FFFF_FFFF_FFFF;
		limit_plan[11] = LIMIT_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with a limit of 126.
		write_limit(64'd126);
		push_byte(8'h00, 1'b0);
		push_byte(8'h7E, 1'b0);
		// Over the limit, then a byte that is dropped and ends the buffer.
		push_byte(8'h7F, 1'b0);
		push_byte(8'h05, 1'b1);
		// Trailing zero group.
		push_byte(8'h80, 1'b0);
		push_byte(8'h00, 1'b1);
		// Buffer ends while a continuation is expected.
		push_byte(8'hFF, 1'b1);
		// Tenth byte carries more than the last bit of the value.
		repeat (9) push_byte(8'hFF, 1'b0);
		push_byte(8'h02, 1'b1);
		// Ten continuation bytes, the tenth ending the buffer; too long wins over truncation.
		repeat (9) push_byte(8'h80, 1'b0);
		push_byte(8'h80, 1'b1);

		// Random part in three idle phases, four limit settings each.
		target = bytes_sent;
		for (int s = 0; s < SEGMENTS; s++) begin
			if (s == 4) begin
				src_idle_pct = 68;
				sink_idle_pct = 11;
			end else if (s == 8) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			write_limit(limit_plan[s]);
			target += SEG_BYTES;
			while (bytes_sent < target) begin
				send_buffer();
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
